// File: src/cdc_pkg.sv
// ============================================================================
// cdc_pkg: shared types, codes and calendar functions
// Field widths, operation and order codes, controller state and command
// types, and the leap-year and month-length functions of the date counter.
// ============================================================================
package cdc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int STEP_W     = 16;
    localparam int CNT_W      = (COUNT_BITS < STEP_W) ? COUNT_BITS : STEP_W;

    localparam int KIND_W  = 3;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORDER_W = 2;

    // Width of a year plus a step count, with one carry bit.
    localparam int SUM_W = ((YEAR_W > CNT_W) ? YEAR_W : CNT_W) + 1;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  YEAR_RESET = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_28     = DAY_W'(28);
    localparam logic [DAY_W-1:0]   DAY_29     = DAY_W'(29);
    localparam logic [DAY_W-1:0]   DAY_30     = DAY_W'(30);
    localparam logic [DAY_W-1:0]   DAY_31     = DAY_W'(31);

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [ORDER_W-1:0] t_order;

    localparam t_kind KIND_LOAD      = 3'd0;
    localparam t_kind KIND_FWD_DAYS  = 3'd1;
    localparam t_kind KIND_BACK_DAYS = 3'd2;
    localparam t_kind KIND_ADD_YEARS = 3'd3;
    localparam t_kind KIND_SUB_YEARS = 3'd4;
    localparam t_kind KIND_COMPARE   = 3'd5;

    localparam t_order ORDER_EQUAL   = 2'd0;
    localparam t_order ORDER_LATER   = 2'd1;
    localparam t_order ORDER_EARLIER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DAY,
        ST_YEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic day_step;
        logic day_end;
        logic year_apply;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_day;
        logic is_year;
        logic day_done;
    } t_status;

    // Division by 100 through a fixed-point reciprocal: for years below 2**14
    // the fraction bits of year * 5243 / 2**19 stay under 4096 exactly when
    // the year is a multiple of 100, and the integer bits are year / 100.
    localparam int LEAP_PROD_W  = 27;
    localparam int LEAP_FRAC_W  = 19;
    localparam int LEAP_RECIP   = 5243;
    localparam int LEAP_THRESH  = 4096;

    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [LEAP_PROD_W-1:0] prod;
        logic                   div100;
        logic [1:0]             cent_low;
        prod     = LEAP_PROD_W'(year) * LEAP_PROD_W'(LEAP_RECIP);
        div100   = prod[LEAP_FRAC_W-1:0] < LEAP_FRAC_W'(LEAP_THRESH);
        cent_low = prod[LEAP_FRAC_W+1:LEAP_FRAC_W];
        return div100 ? (cent_low == 2'd0) : (year[1:0] == 2'd0);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] year,
                                                   input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_31;
            4'd2:                                        len = is_leap(year) ? DAY_29 : DAY_28;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_30;
            default:                                     len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: src/cdc_ctrl.sv
// ============================================================================
// cdc_ctrl: sequencing controller of the date counter
// Takes a word from the input channel, walks the datapath through the
// execute, day-step and year-apply phases, and hands the result word to the
// output register when that register is free.
// ============================================================================
module cdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cdc_pkg::t_status i_status,
    output cdc_pkg::t_cmd    o_cmd
);
    import cdc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_day) begin
                    n_state = ST_DAY;
                end else if (i_status.is_year) begin
                    n_state = ST_YEAR;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DAY: begin
                if (i_status.day_done) begin
                    o_cmd.day_end = 1'b1;
                    n_state       = ST_EMIT;
                end else begin
                    o_cmd.day_step = 1'b1;
                end
            end
            ST_YEAR: begin
                o_cmd.year_apply = 1'b1;
                n_state          = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("result word not presented after emit");

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter execute");

    a_day_loop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DAY && !i_status.day_done) |=> (r_state == ST_DAY))
        else $error("day loop left before its count ran out");

endmodule

// File: src/cdc_dp.sv
// ============================================================================
// cdc_dp: datapath of the date counter
// Holds the stored date, the latched input word, the working date and the
// step counter of a day walk, and the output register of the result word.
// ============================================================================
module cdc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdc_pkg::t_cmd                 i_cmd,
    output cdc_pkg::t_status              o_status,
    input  logic [cdc_pkg::KIND_W-1:0]    i_kind,
    input  logic [cdc_pkg::YEAR_W-1:0]    i_year_in,
    input  logic [cdc_pkg::MONTH_W-1:0]   i_month_in,
    input  logic [cdc_pkg::DAY_W-1:0]     i_day_in,
    input  logic [cdc_pkg::STEP_W-1:0]    i_step_count,
    output logic [cdc_pkg::YEAR_W-1:0]    o_year_out,
    output logic [cdc_pkg::MONTH_W-1:0]   o_month_out,
    output logic [cdc_pkg::DAY_W-1:0]     o_day_out,
    output logic [cdc_pkg::ORDER_W-1:0]   o_order,
    output logic                          o_refused
);
    import cdc_pkg::*;

    // Stored date.
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day, n_day;
    // Latched input word.
    t_kind              r_kind;
    logic [YEAR_W-1:0]  r_yi;
    logic [MONTH_W-1:0] r_mi;
    logic [DAY_W-1:0]   r_di;
    logic [CNT_W-1:0]   r_cnt;
    // Working date and day counter.
    logic [YEAR_W-1:0]  r_wy, n_wy;
    logic [MONTH_W-1:0] r_wm, n_wm;
    logic [DAY_W-1:0]   r_wd, n_wd;
    logic [CNT_W-1:0]   r_steps, n_steps;
    logic               r_ok, n_ok;
    t_order             r_order, n_order;
    logic               r_refused, n_refused;

    logic               load_ok;
    logic [SUM_W-1:0]   add_sum;
    logic               sub_ok;
    logic [DAY_W-1:0]   wlen;
    logic [DAY_W-1:0]   prev_len;

    assign o_status.is_day   = (r_kind == KIND_FWD_DAYS) || (r_kind == KIND_BACK_DAYS);
    assign o_status.is_year  = (r_kind == KIND_ADD_YEARS) || (r_kind == KIND_SUB_YEARS);
    assign o_status.day_done = (r_steps == '0) || !r_ok;

    assign load_ok  = (r_yi >= YEAR_MIN) && (r_yi <= YEAR_MAX) && (r_di >= DAY_FIRST)
                      && (r_di <= month_len(r_yi, r_mi));
    assign add_sum  = SUM_W'(r_year) + SUM_W'(r_cnt);
    assign sub_ok   = SUM_W'(r_cnt) < SUM_W'(r_year);
    assign wlen     = month_len(r_wy, r_wm);
    assign prev_len = month_len(r_wy, r_wm - MONTH_W'(1));

    always_comb begin
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_wy      = r_wy;
        n_wm      = r_wm;
        n_wd      = r_wd;
        n_steps   = r_steps;
        n_ok      = r_ok;
        n_order   = r_order;
        n_refused = r_refused;

        if (i_cmd.exec) begin
            n_order   = ORDER_EQUAL;
            n_refused = 1'b0;
            case (r_kind) inside
                KIND_LOAD: begin
                    // Month length is zero for a month code outside 1 to 12.
                    if (load_ok) begin
                        n_year  = r_yi;
                        n_month = r_mi;
                        n_day   = r_di;
                    end
                    n_refused = !load_ok;
                end
                KIND_FWD_DAYS, KIND_BACK_DAYS: begin
                    n_wy    = r_year;
                    n_wm    = r_month;
                    n_wd    = r_day;
                    n_steps = r_cnt;
                    n_ok    = 1'b1;
                end
                KIND_ADD_YEARS: begin
                    n_wy = add_sum[YEAR_W-1:0];
                    n_ok = add_sum <= SUM_W'(YEAR_MAX);
                end
                KIND_SUB_YEARS: begin
                    n_wy = r_year - YEAR_W'(r_cnt);
                    n_ok = sub_ok;
                end
                KIND_COMPARE: begin
                    if (r_year != r_yi) begin
                        n_order = (r_year > r_yi) ? ORDER_LATER : ORDER_EARLIER;
                    end else if (r_month != r_mi) begin
                        n_order = (r_month > r_mi) ? ORDER_LATER : ORDER_EARLIER;
                    end else if (r_day != r_di) begin
                        n_order = (r_day > r_di) ? ORDER_LATER : ORDER_EARLIER;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.day_step) begin
            n_steps = r_steps - CNT_W'(1);
            if (r_kind == KIND_FWD_DAYS) begin
                if (r_wm == MONTH_DEC && r_wd == DAY_31) begin
                    if (r_wy >= YEAR_MAX) begin
                        n_ok = 1'b0;
                    end else begin
                        n_wy = r_wy + YEAR_W'(1);
                        n_wm = MONTH_JAN;
                        n_wd = DAY_FIRST;
                    end
                end else if (r_wd >= wlen) begin
                    n_wm = r_wm + MONTH_W'(1);
                    n_wd = DAY_FIRST;
                end else begin
                    n_wd = r_wd + DAY_W'(1);
                end
            end else begin
                if (r_wm == MONTH_JAN && r_wd == DAY_FIRST) begin
                    if (r_wy <= YEAR_MIN) begin
                        n_ok = 1'b0;
                    end else begin
                        n_wy = r_wy - YEAR_W'(1);
                        n_wm = MONTH_DEC;
                        n_wd = DAY_31;
                    end
                end else if (r_wd == DAY_FIRST) begin
                    n_wm = r_wm - MONTH_W'(1);
                    n_wd = prev_len;
                end else begin
                    n_wd = r_wd - DAY_W'(1);
                end
            end
        end

        if (i_cmd.day_end) begin
            if (r_ok) begin
                n_year  = r_wy;
                n_month = r_wm;
                n_day   = r_wd;
            end
            n_steps   = '0;
            n_refused = !r_ok;
        end

        if (i_cmd.year_apply) begin
            if (r_ok) begin
                n_year = r_wy;
                // A leap day that lands in a common year becomes the 28th.
                if (r_month == MONTH_FEB && r_day == DAY_29 && !is_leap(r_wy)) begin
                    n_day = DAY_28;
                end
            end
            n_refused = !r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YEAR_RESET;
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
            r_steps <= '0;
        end else begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_yi   <= i_year_in;
            r_mi   <= i_month_in;
            r_di   <= i_day_in;
            r_cnt  <= i_step_count[CNT_W-1:0];
        end
        r_wy      <= n_wy;
        r_wm      <= n_wm;
        r_wd      <= n_wd;
        r_ok      <= n_ok;
        r_order   <= n_order;
        r_refused <= n_refused;
        if (i_cmd.emit) begin
            o_year_out  <= r_year;
            o_month_out <= r_month;
            o_day_out   <= r_day;
            o_order     <= r_order;
            o_refused   <= r_refused;
        end
    end

    a_step_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.day_step |=> (r_steps == $past(r_steps) - CNT_W'(1)))
        else $error("day counter did not count down by one");

    a_refused_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.day_end && !r_ok) |=> ($stable(r_year) && $stable(r_month) && $stable(r_day)))
        else $error("stored date changed on a refused day walk");

    a_emit_shows_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (o_year_out == r_year && o_month_out == r_month && o_day_out == r_day))
        else $error("result word does not match the stored date");

endmodule

// File: src/calendar_date_counter_unit.sv
// ============================================================================
// calendar_date_counter_unit: Gregorian day, month and year counter
// Top level joining the sequencing controller and the date datapath.
// ============================================================================
// The unit holds one date between 0001-01-01 and 9999-12-31 (reset value
// 2000-01-01) and takes one word at a time: load, walk forward or back a
// number of days, add or subtract years, or compare. Each word returns one
// result word with the stored date, the compare order and a refused flag. A
// load, compare or unused code passes through execute and emit, and a year
// step also passes through year-apply. A day walk steps through the days
// in turn, as the datapath advances the working date by one calendar day
// per clock, and a walk refused at its k-th day stops there. A word whose
// result finds the output register still full waits in its last phase
// until that register is taken. The result sits in an output register, so
// the next word can be accepted while the previous result still waits to be
// taken.
module calendar_date_counter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cdc_pkg::KIND_W-1:0]    i_kind,
    input  logic [cdc_pkg::YEAR_W-1:0]    i_year_in,
    input  logic [cdc_pkg::MONTH_W-1:0]   i_month_in,
    input  logic [cdc_pkg::DAY_W-1:0]     i_day_in,
    input  logic [cdc_pkg::STEP_W-1:0]    i_step_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cdc_pkg::YEAR_W-1:0]    o_year_out,
    output logic [cdc_pkg::MONTH_W-1:0]   o_month_out,
    output logic [cdc_pkg::DAY_W-1:0]     o_day_out,
    output logic [cdc_pkg::ORDER_W-1:0]   o_order,
    output logic                          o_refused
);
    import cdc_pkg::*;

    t_cmd    cmd;
    t_status status;

    cdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cdc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_year_in    (i_year_in),
        .i_month_in   (i_month_in),
        .i_day_in     (i_day_in),
        .i_step_count (i_step_count),
        .o_year_out   (o_year_out),
        .o_month_out  (o_month_out),
        .o_day_out    (o_day_out),
        .o_order      (o_order),
        .o_refused    (o_refused)
    );

endmodule
